### rtl/core/bst_pkg.sv
// bst_pkg: shared types and constants for the bencode stream tokenizer.
// Used by bst_front, bst_queue, bst_back and bencode_stream_tokenizer.
package bst_pkg;

    localparam int MAX_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int NEST_W        = 5;

    localparam logic [31:0] MAX_LEN_RST = 32'hFFFF_FFFF;
    localparam logic [63:0] MAG_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_NEG     = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        CL_DIGIT,
        CL_E,
        CL_I,
        CL_L,
        CL_D,
        CL_MINUS,
        CL_COLON,
        CL_OTHER
    } byte_cls_t;

    typedef enum logic [2:0] {
        TK_INT   = 3'd0,
        TK_SBYTE = 3'd1,
        TK_EMPTY = 3'd2,
        TK_LIST  = 3'd3,
        TK_DICT  = 3'd4,
        TK_CLOSE = 3'd5,
        TK_ERROR = 3'd6
    } tok_kind_t;

    typedef struct packed {
        byte_cls_t   cls;
        logic [7:0]  data;
    } item_t;

endpackage

### rtl/core/bst_front.sv
// bst_front: input beat handshake and byte classification.
// Depends on bst_pkg; feeds bst_queue.
module bst_front (
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_byte_req,
    input  logic           q_full,
    output logic           q_push,
    output bst_pkg::item_t q_item
);
    import bst_pkg::*;

    byte_cls_t cls;

    always_comb begin
        case (s_byte_req) inside
            [CH_0:CH_9]: cls = CL_DIGIT;
            CH_E:        cls = CL_E;
            CH_I:        cls = CL_I;
            CH_L:        cls = CL_L;
            CH_D:        cls = CL_D;
            CH_MINUS:    cls = CL_MINUS;
            CH_COLON:    cls = CL_COLON;
            default:     cls = CL_OTHER;
        endcase
    end

    assign s_ready     = !q_full;
    assign q_push      = s_valid && !q_full;
    assign q_item.cls  = cls;
    assign q_item.data = s_byte_req;

endmodule

### rtl/core/bst_queue.sv
// bst_queue: short FIFO of classified bytes between front and back.
// Depends on bst_pkg (item_t, QUEUE_DEPTH).
module bst_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bst_pkg::item_t wr_item,
    output logic           full,
    output logic           rd_valid,
    input  logic           rd_ready,
    output bst_pkg::item_t rd_item
);
    import bst_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t            buf_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             pop;

    assign full     = (count_reg == QCW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = buf_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### rtl/core/bst_back.sv
// bst_back: parser state machine, nesting stack and output register.
// Depends on bst_pkg; consumes classified bytes from bst_queue.
module bst_back #(
    parameter int MAX_DEPTH = bst_pkg::MAX_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [31:0]                 cfg_wr_data,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  bst_pkg::item_t              q_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_token_kind,
    output logic signed [63:0]          m_int_value,
    output logic [7:0]                  m_data_byte,
    output logic                        m_string_last,
    output logic                        m_is_key,
    output logic [bst_pkg::NEST_W-1:0]  m_nest_depth,
    output logic                        m_top_done
);
    import bst_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INT_START,
        PH_INT_MINUS,
        PH_INT_DIGITS,
        PH_STR_LEN,
        PH_STR_DATA
    } phase_t;

    typedef struct packed {
        logic is_dict;
        logic exp_key;
    } stack_ent_t;

    phase_t             phase_reg, phase_next;
    logic [DW-1:0]      depth_reg, depth_next;
    stack_ent_t         top_reg, top_next;
    stack_ent_t         sec_reg, sec_next;
    logic               sec_mem_reg, sec_mem_next;
    logic [63:0]        acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [32:0]        len_reg, len_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        max_len_reg, max_len_next;

    logic               m_valid_reg, m_valid_next;
    tok_kind_t          m_kind_reg, m_kind_next;
    logic [63:0]        m_int_reg, m_int_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;
    logic               m_key_reg, m_key_next;
    logic [NEST_W-1:0]  m_nest_reg, m_nest_next;
    logic               m_done_reg, m_done_next;

    stack_ent_t         mem [MAX_DEPTH];
    stack_ent_t         mem_rd_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    stack_ent_t         mem_wdata;

    logic               pop;
    byte_cls_t          cls;
    logic [7:0]         c;
    logic               has_top, top_dict, key_pos, val_in_dict;
    stack_ent_t         sec_eff;
    logic [67:0]        int_x10;
    logic               int_ovf;
    logic [35:0]        len_x10;
    logic [32:0]        len_sat;

    logic               tok_vld;
    tok_kind_t          tok_kind;
    logic [63:0]        tok_int;
    logic [7:0]         tok_byte;
    logic               tok_last, tok_key, tok_done;
    logic [DW-1:0]      tok_depth;
    logic               do_fail;

    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;
    assign cls     = q_item.cls;
    assign c       = q_item.data;

    assign has_top     = (depth_reg != '0);
    assign top_dict    = has_top && top_reg.is_dict;
    assign key_pos     = top_dict && top_reg.exp_key;
    assign val_in_dict = top_dict && !top_reg.exp_key;
    assign sec_eff     = sec_mem_reg ? mem_rd_reg : sec_reg;

    assign int_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {64'd0, c[3:0]};
    assign int_ovf = int_x10 > {4'd0, (neg_reg ? MAG_NEG : MAG_POS)};
    assign len_x10 = {1'b0, len_reg[31:0], 3'b000} + {3'b000, len_reg[31:0], 1'b0}
                   + {32'd0, c[3:0]};
    assign len_sat = (len_x10 > 36'h1_0000_0000) ? 33'h1_0000_0000 : len_x10[32:0];

    assign mem_waddr = AW'(depth_reg - 1'b1);
    assign mem_raddr = AW'(depth_reg - DW'(3));
    assign mem_wdata = '{is_dict: top_reg.is_dict, exp_key: top_reg.exp_key | top_dict};

    always_comb begin
        phase_next   = phase_reg;
        depth_next   = depth_reg;
        top_next     = top_reg;
        sec_next     = sec_eff;
        sec_mem_next = 1'b0;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        max_len_next = cfg_wr_en ? cfg_wr_data : max_len_reg;
        mem_we       = 1'b0;
        do_fail      = 1'b0;
        tok_vld      = 1'b0;
        tok_kind     = TK_INT;
        tok_int      = '0;
        tok_byte     = '0;
        tok_last     = 1'b0;
        tok_key      = 1'b0;
        tok_done     = 1'b0;
        tok_depth    = depth_reg;

        if (pop) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (cls == CL_E) begin
                        if (!has_top || val_in_dict) begin
                            do_fail = 1'b1;
                        end else begin
                            depth_next = depth_reg - 1'b1;
                            top_next   = sec_eff;
                            tok_vld    = 1'b1;
                            tok_kind   = TK_CLOSE;
                            tok_depth  = depth_reg - 1'b1;
                            tok_done   = (depth_reg == DW'(1));
                        end
                    end else if (key_pos) begin
                        if (cls != CL_DIGIT) begin
                            do_fail = 1'b1;
                        end else begin
                            top_next.exp_key = 1'b0;
                            len_next         = {29'd0, c[3:0]};
                            phase_next       = PH_STR_LEN;
                        end
                    end else if (cls == CL_D || cls == CL_L) begin
                        if (depth_reg >= DW'(MAX_DEPTH)) begin
                            do_fail = 1'b1;
                        end else begin
                            mem_we           = has_top;
                            sec_next         = mem_wdata;
                            top_next.is_dict = (cls == CL_D);
                            top_next.exp_key = (cls == CL_D);
                            depth_next       = depth_reg + 1'b1;
                            tok_vld          = 1'b1;
                            tok_kind         = (cls == CL_D) ? TK_DICT : TK_LIST;
                            tok_depth        = depth_reg + 1'b1;
                        end
                    end else if (cls == CL_I) begin
                        top_next.exp_key = top_reg.exp_key | top_dict;
                        acc_next         = '0;
                        neg_next         = 1'b0;
                        phase_next       = PH_INT_START;
                    end else if (cls == CL_DIGIT) begin
                        top_next.exp_key = top_reg.exp_key | top_dict;
                        len_next         = {29'd0, c[3:0]};
                        phase_next       = PH_STR_LEN;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_INT_START: begin
                    if (cls == CL_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_INT_MINUS;
                    end else if (cls == CL_DIGIT) begin
                        acc_next   = {60'd0, c[3:0]};
                        phase_next = PH_INT_DIGITS;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_INT_MINUS: begin
                    if (cls == CL_DIGIT) begin
                        acc_next   = {60'd0, c[3:0]};
                        phase_next = PH_INT_DIGITS;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_INT_DIGITS: begin
                    if (cls == CL_DIGIT) begin
                        if (int_ovf) begin
                            do_fail = 1'b1;
                        end else begin
                            acc_next = int_x10[63:0];
                        end
                    end else if (cls == CL_E) begin
                        phase_next = PH_IDLE;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        tok_vld    = 1'b1;
                        tok_kind   = TK_INT;
                        tok_int    = neg_reg ? (~acc_reg + 64'd1) : acc_reg;
                        tok_done   = !has_top;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_STR_LEN: begin
                    if (cls == CL_DIGIT) begin
                        if (!len_reg[32]) begin
                            len_next = len_sat;
                        end
                    end else if (cls == CL_COLON) begin
                        if (len_reg > {1'b0, max_len_reg}) begin
                            do_fail = 1'b1;
                        end else if (len_reg == '0) begin
                            phase_next = PH_IDLE;
                            tok_vld    = 1'b1;
                            tok_kind   = TK_EMPTY;
                            tok_last   = 1'b1;
                            tok_key    = val_in_dict;
                            tok_done   = !has_top;
                        end else begin
                            rem_next   = len_reg[31:0];
                            phase_next = PH_STR_DATA;
                        end
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_STR_DATA: begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == 32'd1) begin
                        phase_next = PH_IDLE;
                    end
                    tok_vld  = 1'b1;
                    tok_kind = TK_SBYTE;
                    tok_byte = c;
                    tok_last = (rem_reg == 32'd1);
                    tok_key  = val_in_dict;
                    tok_done = (rem_reg == 32'd1) && !has_top;
                end
                default: begin
                    do_fail = 1'b1;
                end
            endcase

            if (do_fail) begin
                phase_next = PH_IDLE;
                depth_next = '0;
                acc_next   = '0;
                neg_next   = 1'b0;
                rem_next   = '0;
                mem_we     = 1'b0;
                tok_vld    = 1'b1;
                tok_kind   = TK_ERROR;
                tok_int    = '0;
                tok_byte   = '0;
                tok_last   = 1'b0;
                tok_key    = 1'b0;
                tok_done   = 1'b0;
                tok_depth  = '0;
            end

            if (phase_reg == PH_IDLE && cls == CL_E && !do_fail) begin
                sec_mem_next = 1'b1;
            end
        end

        m_valid_next = pop ? tok_vld : (m_valid_reg && !m_ready);
        m_kind_next  = m_kind_reg;
        m_int_next   = m_int_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_key_next   = m_key_reg;
        m_nest_next  = m_nest_reg;
        m_done_next  = m_done_reg;
        if (pop && tok_vld) begin
            m_kind_next = tok_kind;
            m_int_next  = tok_int;
            m_byte_next = tok_byte;
            m_last_next = tok_last;
            m_key_next  = tok_key;
            m_nest_next = NEST_W'(tok_depth);
            m_done_next = tok_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            depth_reg   <= '0;
            sec_mem_reg <= 1'b0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            len_reg     <= '0;
            rem_reg     <= '0;
            max_len_reg <= MAX_LEN_RST;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            depth_reg   <= depth_next;
            sec_mem_reg <= sec_mem_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            len_reg     <= len_next;
            rem_reg     <= rem_next;
            max_len_reg <= max_len_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg    <= top_next;
        sec_reg    <= sec_next;
        m_kind_reg <= m_kind_next;
        m_int_reg  <= m_int_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_key_reg  <= m_key_next;
        m_nest_reg <= m_nest_next;
        m_done_reg <= m_done_next;
    end

    // stack entries below the top two; registered read of the entry under the current second
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    assign m_valid       = m_valid_reg;
    assign m_token_kind  = m_kind_reg;
    assign m_int_value   = m_int_reg;
    assign m_data_byte   = m_byte_reg;
    assign m_string_last = m_last_reg;
    assign m_is_key      = m_key_reg;
    assign m_nest_depth  = m_nest_reg;
    assign m_top_done    = m_done_reg;

endmodule

### rtl/core/bencode_stream_tokenizer.sv
// bencode_stream_tokenizer: top level of the streaming bencode tokenizer.
// Depends on bst_pkg, bst_front, bst_queue and bst_back.
//
// Takes one bencoded byte per input beat and gives at most one token beat per
// byte, sustaining one byte per clock unless the output stalls. A byte goes
// through the classifier into a two-entry queue, then the parser consumes it
// and loads the output register. The parser holds the top two nesting entries
// in flops and the deeper ones in a MAX_DEPTH-entry stack memory with a
// registered read, so containers open and close back to back without a stall.
// The stack needs no clearing after reset. Write max_string_length only while
// no byte is in flight.
module bencode_stream_tokenizer #(
    parameter int MAX_DEPTH = bst_pkg::MAX_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [31:0]                 cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_byte_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_token_kind,
    output logic signed [63:0]          m_int_value,
    output logic [7:0]                  m_data_byte,
    output logic                        m_string_last,
    output logic                        m_is_key,
    output logic [bst_pkg::NEST_W-1:0]  m_nest_depth,
    output logic                        m_top_done
);
    import bst_pkg::*;

    logic  q_full;
    logic  q_push;
    item_t q_wr_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_rd_item;

    bst_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_req (s_byte_req),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_wr_item)
    );

    bst_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_item  (q_wr_item),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_rd_item)
    );

    bst_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_rd_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_int_value   (m_int_value),
        .m_data_byte   (m_data_byte),
        .m_string_last (m_string_last),
        .m_is_key      (m_is_key),
        .m_nest_depth  (m_nest_depth),
        .m_top_done    (m_top_done)
    );

    a_error_clears_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == TK_ERROR) |-> (m_nest_depth == '0) && !m_top_done)
        else $error("error token with nonzero depth or done");

    a_done_at_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_top_done |-> (m_nest_depth == '0) &&
            (m_token_kind != TK_LIST) && (m_token_kind != TK_DICT))
        else $error("top_done on a token inside a container");

    a_last_on_string: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_string_last || m_is_key) |->
            (m_token_kind == TK_SBYTE) || (m_token_kind == TK_EMPTY))
        else $error("string flags on a non-string token");

    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && (!m_valid || m_ready) |=> !q_full)
        else $error("queue stayed full while the parser could consume");

endmodule

### dv/bencode_stream_tokenizer_test.sv
`timescale 1ns / 1ps
// bencode_stream_tokenizer_test: self-checking bench for bencode_stream_tokenizer.
// Drives directed and generated bencode byte streams, checks each token beat
// against a parser model kept here or the directed table. Needs bst_pkg and the tokenizer RTL only.
module bencode_stream_tokenizer_test;
    import bst_pkg::*;

    localparam int DEPTH_LIMIT   = MAX_DEPTH_DEF;
    localparam int RUN_LIMIT     = 500000;
    localparam int BYTES_TOTAL   = 1950;
    localparam int NUM_PHASES    = 6;
    localparam int NUM_DIRECTED  = 24;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [7:0]  CH_JUNK = 8'h78;
    localparam logic [63:0] LEN_SAT = 64'h1_0000_0000;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_INT_START,
        PS_INT_MINUS,
        PS_INT_DIGITS,
        PS_STR_LEN,
        PS_STR_DATA
    } parse_state_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [63:0] ival;
        logic [7:0]  dbyte;
        logic        last;
        logic        key;
        logic [4:0]  depth;
        logic        done;
    } token_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fixed;
        tok_kind_t  kind;
        logic [4:0] depth;
        logic       key;
        logic       done;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_byte_req;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_token_kind;
    logic signed [63:0] m_int_value;
    logic [7:0]         m_data_byte;
    logic               m_string_last;
    logic               m_is_key;
    logic [NEST_W-1:0]  m_nest_depth;
    logic               m_top_done;

    // parser model state
    parse_state_t ps;
    logic [63:0]  acc;
    logic         neg;
    logic [31:0]  str_left;
    int           depth;
    logic         is_dict [DEPTH_LIMIT];
    logic         want_key [DEPTH_LIMIT];
    logic [31:0]  max_len;

    token_t     expected_tokens [$];
    logic [7:0] stream_q [$];

    int bytes_sent;
    int tokens_checked;
    int mismatches;
    int cycle_count;
    int kind_seen [8];
    bit calm;
    bit src_idle_on;
    bit hold_start;

    // after reset: errors, dict key rules, list with extreme content bytes, bad ints
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        {CH_E,     1'b1, TK_ERROR, 5'd0, 1'b0, 1'b0},
        {8'h00,    1'b1, TK_ERROR, 5'd0, 1'b0, 1'b0},
        {CH_D,     1'b1, TK_DICT,  5'd1, 1'b0, 1'b0},
        {CH_I,     1'b1, TK_ERROR, 5'd0, 1'b0, 1'b0},
        {CH_D,     1'b1, TK_DICT,  5'd1, 1'b0, 1'b0},
        {CH_0,     1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_COLON, 1'b1, TK_EMPTY, 5'd1, 1'b1, 1'b0},
        {CH_E,     1'b1, TK_ERROR, 5'd0, 1'b0, 1'b0},
        {CH_L,     1'b1, TK_LIST,  5'd1, 1'b0, 1'b0},
        {8'h32,    1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_COLON, 1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {8'hFF,    1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {8'h00,    1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_I,     1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_MINUS, 1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_0,     1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_E,     1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_E,     1'b1, TK_CLOSE, 5'd0, 1'b0, 1'b1},
        {CH_I,     1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_E,     1'b1, TK_ERROR, 5'd0, 1'b0, 1'b0},
        {CH_COLON, 1'b1, TK_ERROR, 5'd0, 1'b0, 1'b0},
        {CH_I,     1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_MINUS, 1'b0, TK_INT,   5'd0, 1'b0, 1'b0},
        {CH_E,     1'b1, TK_ERROR, 5'd0, 1'b0, 1'b0}
    };

    bencode_stream_tokenizer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_req    (s_byte_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_int_value   (m_int_value),
        .m_data_byte   (m_data_byte),
        .m_string_last (m_string_last),
        .m_is_key      (m_is_key),
        .m_nest_depth  (m_nest_depth),
        .m_top_done    (m_top_done)
    );

    always #5 aclk = ~aclk;

    function automatic void reset_parser();
        ps = PS_IDLE;
        acc = '0;
        neg = 1'b0;
        str_left = '0;
        depth = 0;
        for (int i = 0; i < DEPTH_LIMIT; i++) begin
            is_dict[i] = 1'b0;
            want_key[i] = 1'b0;
        end
        max_len = MAX_LEN_RST;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic token_t make_token(tok_kind_t k, logic [63:0] v, logic [7:0] b,
                                          logic l, logic key, logic done);
        token_t t;
        t.kind = k;
        t.ival = v;
        t.dbyte = b;
        t.last = l;
        t.key = key;
        t.depth = depth[4:0];
        t.done = done;
        return t;
    endfunction

    function automatic token_t parse_fault();
        ps = PS_IDLE;
        acc = '0;
        neg = 1'b0;
        str_left = '0;
        depth = 0;
        return make_token(TK_ERROR, '0, '0, 1'b0, 1'b0, 1'b0);
    endfunction

    // advances the model by one byte; returns 1 when the byte yields a token
    function automatic bit parse_byte(input logic [7:0] c, output token_t t);
        logic        in_dict;
        logic [63:0] d;
        logic [63:0] lim;
        logic [63:0] v;
        int          top;
        top = (depth > 0) ? depth - 1 : 0;
        in_dict = depth > 0 && is_dict[top];
        d = {56'd0, c - CH_0};
        case (ps)
            PS_IDLE: begin
                if (c == CH_E) begin
                    if (depth == 0 || (in_dict && !want_key[top])) begin
                        t = parse_fault();
                        return 1'b1;
                    end
                    depth--;
                    t = make_token(TK_CLOSE, '0, '0, 1'b0, 1'b0, depth == 0);
                    return 1'b1;
                end
                if (in_dict && want_key[top]) begin
                    if (!is_digit(c)) begin
                        t = parse_fault();
                        return 1'b1;
                    end
                    want_key[top] = 1'b0;
                    acc = d;
                    ps = PS_STR_LEN;
                    return 1'b0;
                end
                if (c == CH_D || c == CH_L) begin
                    if (depth >= DEPTH_LIMIT) begin
                        t = parse_fault();
                        return 1'b1;
                    end
                    if (in_dict) want_key[top] = 1'b1;
                    depth++;
                    is_dict[depth-1] = (c == CH_D);
                    want_key[depth-1] = (c == CH_D);
                    t = make_token((c == CH_D) ? TK_DICT : TK_LIST, '0, '0, 1'b0, 1'b0, 1'b0);
                    return 1'b1;
                end
                if (c == CH_I || is_digit(c)) begin
                    if (in_dict) want_key[top] = 1'b1;
                    acc = (c == CH_I) ? 64'd0 : d;
                    neg = 1'b0;
                    ps = (c == CH_I) ? PS_INT_START : PS_STR_LEN;
                    return 1'b0;
                end
                t = parse_fault();
                return 1'b1;
            end
            PS_INT_START, PS_INT_MINUS: begin
                if (ps == PS_INT_START && c == CH_MINUS) begin
                    neg = 1'b1;
                    ps = PS_INT_MINUS;
                    return 1'b0;
                end
                if (!is_digit(c)) begin
                    t = parse_fault();
                    return 1'b1;
                end
                acc = d;
                ps = PS_INT_DIGITS;
                return 1'b0;
            end
            PS_INT_DIGITS: begin
                if (is_digit(c)) begin
                    lim = neg ? MAG_NEG : MAG_POS;
                    if (acc > (lim - d) / 10) begin
                        t = parse_fault();
                        return 1'b1;
                    end
                    acc = acc * 10 + d;
                    return 1'b0;
                end
                if (c == CH_E) begin
                    v = neg ? -acc : acc;
                    ps = PS_IDLE;
                    acc = '0;
                    neg = 1'b0;
                    t = make_token(TK_INT, v, '0, 1'b0, 1'b0, depth == 0);
                    return 1'b1;
                end
                t = parse_fault();
                return 1'b1;
            end
            PS_STR_LEN: begin
                if (is_digit(c)) begin
                    if (acc < LEN_SAT) begin
                        acc = acc * 10 + d;
                        if (acc > LEN_SAT) acc = LEN_SAT;
                    end
                    return 1'b0;
                end
                if (c == CH_COLON) begin
                    if (acc > {32'd0, max_len}) begin
                        t = parse_fault();
                        return 1'b1;
                    end
                    if (acc == 0) begin
                        ps = PS_IDLE;
                        t = make_token(TK_EMPTY, '0, '0, 1'b1, in_dict && !want_key[top],
                                       depth == 0);
                        return 1'b1;
                    end
                    str_left = acc[31:0];
                    acc = '0;
                    ps = PS_STR_DATA;
                    return 1'b0;
                end
                t = parse_fault();
                return 1'b1;
            end
            default: begin
                str_left--;
                if (str_left == 0) ps = PS_IDLE;
                t = make_token(TK_SBYTE, '0, c, str_left == 0, in_dict && !want_key[top],
                               str_left == 0 && depth == 0);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
    endfunction

    function automatic void gen_string();
        int    sel;
        int    len;
        string txt;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            case ($urandom_range(0, 2))
                0: txt = "4294967296";
                1: txt = "99999999999";
                default: txt = "18446744073709551616";
            endcase
            put_text(txt);
            stream_q.push_back(CH_COLON);
            return;
        end
        len = (sel < 15) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        txt = $sformatf("%0d", len);
        if ($urandom_range(0, 9) == 0) txt = {"0", txt};
        put_text(txt);
        stream_q.push_back(CH_COLON);
        if (len <= max_len) repeat (len) stream_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void gen_integer();
        longint v;
        string  txt;
        case ($urandom_range(0, 9))
            0: txt = "9223372036854775807";
            1: txt = "-9223372036854775808";
            2: txt = "9223372036854775808";
            3: txt = "-9223372036854775809";
            4: txt = "-0";
            5: txt = $sformatf("00%0d", $urandom_range(0, 99));
            6: begin
                v = {$urandom, $urandom};
                txt = $sformatf("%0d", v);
            end
            default: begin
                v = $urandom_range(0, 999);
                if ($urandom_range(0, 1)) v = -v;
                txt = $sformatf("%0d", v);
            end
        endcase
        stream_q.push_back(CH_I);
        put_text(txt);
        stream_q.push_back(CH_E);
    endfunction

    function automatic void gen_value(int lvl);
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (lvl >= 4 && sel >= 60) sel = $urandom_range(0, 59);
        if (sel < 30) begin
            gen_integer();
        end else if (sel < 60) begin
            gen_string();
        end else begin
            n = $urandom_range(0, 3);
            stream_q.push_back((sel < 80) ? CH_L : CH_D);
            for (int i = 0; i < n; i++) begin
                if (sel >= 80) gen_string();
                gen_value(lvl + 1);
            end
            stream_q.push_back(CH_E);
        end
    endfunction

    // nesting near and past the stack limit
    function automatic void gen_deep();
        int k;
        k = $urandom_range(DEPTH_LIMIT - 2, DEPTH_LIMIT + 2);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 1)) begin
                stream_q.push_back(CH_D);
                gen_string();
            end else begin
                stream_q.push_back(CH_L);
            end
        end
        gen_value(4);
        repeat (k) stream_q.push_back(CH_E);
    endfunction

    function automatic void gen_chunk();
        int sel;
        int cut;
        if (ps == PS_STR_DATA) begin
            if (str_left <= 200)
                repeat (str_left) stream_q.push_back(8'($urandom_range(0, 255)));
        end else if (ps != PS_IDLE) begin
            stream_q.push_back(CH_JUNK);
        end
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
            stream_q.push_back(8'($urandom_range(0, 255)));
            if (is_digit(stream_q[stream_q.size()-1])) stream_q.push_back(CH_JUNK);
            return;
        end
        if (sel < 12) gen_deep();
        else gen_value(0);
        if (sel >= 88 && stream_q.size() > 1) begin
            cut = $urandom_range(0, stream_q.size() - 1);
            if (sel < 94) begin
                stream_q[cut] = 8'($urandom_range(0, 255));
                if (is_digit(stream_q[cut])) stream_q[cut] = CH_COLON;
            end else begin
                while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
            end
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic fixed, input token_t fixed_tok);
        token_t t;
        bit     has;
        if (!calm && src_idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_req <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        has = parse_byte(b, t);
        if (fixed) begin
            t = fixed_tok;
            has = 1'b1;
        end
        if (has) expected_tokens.push_back(t);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic set_max_len(input logic [31:0] v);
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        max_len = v;
    endtask

    initial begin : token_sink
        int burst;
        int hold;
        int stretch;
        bit idle_on;
        bit hold_done;
        burst = 0;
        hold = 0;
        stretch = 0;
        idle_on = 1'b0;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stretch == 0) begin
                stretch = $urandom_range(50, 300);
                idle_on = $urandom_range(0, 2) != 0;
            end
            stretch--;
            if (hold_start && !hold_done) begin
                hold_done = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if (!calm && idle_on && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : token_check
        token_t got;
        token_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got.kind = tok_kind_t'(m_token_kind);
            got.ival = m_int_value;
            got.dbyte = m_data_byte;
            got.last = m_string_last;
            got.key = m_is_key;
            got.depth = m_nest_depth;
            got.done = m_top_done;
            tokens_checked++;
            if (!$isunknown(m_token_kind)) kind_seen[m_token_kind]++;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected token kind %0d depth %0d", $time,
                             m_token_kind, m_nest_depth);
            end else begin
                want = expected_tokens.pop_front();
                if (got.kind !== want.kind || got.ival !== want.ival ||
                    got.dbyte !== want.dbyte || got.last !== want.last ||
                    got.key !== want.key || got.depth !== want.depth ||
                    got.done !== want.done) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: token %0d mismatch", $time, tokens_checked);
                        $display("  exp kind %0d val %0d byte %02h last %b key %b depth %0d done %b",
                                 want.kind, $signed(want.ival), want.dbyte, want.last,
                                 want.key, want.depth, want.done);
                        $display("  got kind %0d val %0d byte %02h last %b key %b depth %0d done %b",
                                 got.kind, $signed(got.ival), got.dbyte, got.last,
                                 got.key, got.depth, got.done);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
                     expected_tokens.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        token_t      fx;
        logic [31:0] lim;
        int          quota;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_byte_req = '0;
        bytes_sent = 0;
        tokens_checked = 0;
        mismatches = 0;
        cycle_count = 0;
        calm = 1'b0;
        src_idle_on = 1'b1;
        hold_start = 1'b0;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        reset_parser();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            fx.kind = directed_rows[i].kind;
            fx.ival = '0;
            fx.dbyte = '0;
            fx.last = directed_rows[i].kind == TK_EMPTY;
            fx.key = directed_rows[i].key;
            fx.depth = directed_rows[i].depth;
            fx.done = directed_rows[i].done;
            send_byte(directed_rows[i].b, directed_rows[i].fixed, fx);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: lim = MAX_LEN_RST;
                1: lim = 32'd0;
                2: lim = 32'd3;
                3: lim = $urandom_range(1, 12);
                4: lim = 32'd1;
                default: lim = MAX_LEN_RST;
            endcase
            set_max_len(lim);
            calm = (p == NUM_PHASES - 1);
            quota = bytes_sent + BYTES_TOTAL / NUM_PHASES;
            while (bytes_sent < quota) begin
                // long sink stall early on so the input side backs up
                if (p == 0 && bytes_sent > 80) hold_start = 1'b1;
                src_idle_on = $urandom_range(0, 3) != 0;
                gen_chunk();
                while (stream_q.size() > 0) send_byte(stream_q.pop_front(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("%0d bytes over %0d length-limit settings, %0d tokens checked, %0d mismatches",
                 bytes_sent, NUM_PHASES, tokens_checked, mismatches);
        $display("tokens: int %0d, str byte %0d, empty %0d, list %0d, dict %0d, close %0d, err %0d",
                 kind_seen[TK_INT], kind_seen[TK_SBYTE], kind_seen[TK_EMPTY],
                 kind_seen[TK_LIST], kind_seen[TK_DICT], kind_seen[TK_CLOSE],
                 kind_seen[TK_ERROR]);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
